FILE: rtl/mlpg_pkg.sv
// shared types, codes and constants of the led mood pattern generator
package mlpg_pkg;

   // field widths
   localparam int unsigned KIND_W  = 2;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned STEP_W  = 5;
   localparam int unsigned TIMER_W = 16;
   localparam int unsigned REQ_DATA_W = 3 * BYTE_W;

   // default for the text length clamp
   localparam int unsigned MAX_TEXT_LENGTH_DEF = 150;

   // register reset values
   localparam logic [BYTE_W-1:0] REFRESH_DIVIDER_RST     = 8'd5;
   localparam logic [BYTE_W-1:0] TALK_BASE_TICKS_RST     = 8'd150;
   localparam logic [BYTE_W-1:0] TALK_TICKS_PER_BYTE_RST = 8'd12;

   // pattern constants
   localparam logic [BYTE_W-1:0] SAD_MASK     = 8'hE0;
   localparam logic [BYTE_W-1:0] SLEEPY_HIGH  = 8'h03;
   localparam logic [BYTE_W-1:0] SLEEPY_LOW   = 8'h01;
   localparam logic [BYTE_W-1:0] TRIPLE_MASK  = 8'h07;
   localparam logic [BYTE_W-1:0] BLINK_ON     = 8'hFF;
   localparam logic [BYTE_W-1:0] BLINK_OFF    = 8'h00;
   localparam int unsigned       BOUNCE_LEN   = 14;
   localparam int unsigned       SLEEPY_LEN   = 20;
   localparam int unsigned       SLEEPY_SPLIT = 10;

   // item kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_TICK       = 2'd0,
      KIND_SET_MODE   = 2'd1,
      KIND_TALK_START = 2'd2
   } kind_type;

   // mood codes, other codes are dark
   typedef enum logic [BYTE_W-1:0] {
      MODE_IDLE    = 8'd0,
      MODE_BLINK   = 8'd1,
      MODE_SLEEPY  = 8'd2,
      MODE_TRIPLE  = 8'd3,
      MODE_TALKING = 8'd4,
      MODE_SAD     = 8'd5,
      MODE_SWEEP   = 8'd6,
      MODE_CUSTOM  = 8'd7
   } mode_type;

   // register indexes
   typedef enum logic [1:0] {
      CSR_REFRESH_DIVIDER     = 2'd0,
      CSR_TALK_BASE_TICKS     = 2'd1,
      CSR_TALK_TICKS_PER_BYTE = 2'd2
   } csr_index_type;

   // one input item
   typedef struct packed {
      kind_type          kind;
      logic [BYTE_W-1:0] mode_code;
      logic [BYTE_W-1:0] mask_value;
      logic [BYTE_W-1:0] text_length;
   } item_type;

   // configuration registers
   typedef struct packed {
      logic [BYTE_W-1:0] refresh_divider;
      logic [BYTE_W-1:0] talk_base_ticks;
      logic [BYTE_W-1:0] talk_ticks_per_byte;
   } cfg_type;

   // outcome of one item
   typedef struct packed {
      logic              emit;
      logic [BYTE_W-1:0] led_mask;
   } result_type;

endpackage

FILE: rtl/mlpg_pattern.sv
// led mask and next animation step for one refresh of the current mood
module mlpg_pattern (
   input  logic [7:0] mode,
   input  logic [4:0] step,
   input  logic [7:0] stored_mask,
   output logic [7:0] led_mask,
   output logic [4:0] step_next
);

   logic [5:0]  step_inc;
   logic [5:0]  bounce_s;
   logic [5:0]  sleepy_s;
   logic [2:0]  talk_s;
   logic [2:0]  wrap8_s;
   logic [15:0] rot_dbl;
   logic [3:0]  back_pos;

   // step arithmetic for each mood
   always_comb begin
      step_inc = {1'b0, step} + 6'd1;
      // step + 1 stays below 33, so at most two subtractions of 14
      if (step_inc >= 6'(2 * mlpg_pkg::BOUNCE_LEN)) begin
         bounce_s = step_inc - 6'(2 * mlpg_pkg::BOUNCE_LEN);
      end else if (step_inc >= 6'(mlpg_pkg::BOUNCE_LEN)) begin
         bounce_s = step_inc - 6'(mlpg_pkg::BOUNCE_LEN);
      end else begin
         bounce_s = step_inc;
      end
      if (step_inc >= 6'(mlpg_pkg::SLEEPY_LEN)) begin
         sleepy_s = step_inc - 6'(mlpg_pkg::SLEEPY_LEN);
      end else begin
         sleepy_s = step_inc;
      end
      // (3s + 1) mod 8 only needs the low bits
      talk_s   = 3'({step[2:0], 1'b0} + step[2:0] + 3'd1);
      wrap8_s  = step_inc[2:0];
      rot_dbl  = {mlpg_pkg::TRIPLE_MASK, mlpg_pkg::TRIPLE_MASK} << wrap8_s;
      back_pos = 4'(mlpg_pkg::BOUNCE_LEN) - bounce_s[3:0];
   end

   // mask selection
   always_comb begin
      led_mask  = '0;
      step_next = step;
      case (mode)
         mlpg_pkg::MODE_IDLE: begin
            step_next = 5'(bounce_s);
            if (bounce_s < 6'd8) begin
               led_mask = 8'd1 << bounce_s[2:0];
            end else begin
               led_mask = 8'd1 << back_pos[2:0];
            end
         end
         mlpg_pkg::MODE_BLINK: begin
            step_next = {3'd0, step_inc[1:0]};
            led_mask  = (step_inc[1:0] < 2'd2) ? mlpg_pkg::BLINK_ON : mlpg_pkg::BLINK_OFF;
         end
         mlpg_pkg::MODE_SLEEPY: begin
            step_next = 5'(sleepy_s);
            led_mask  = (sleepy_s < 6'(mlpg_pkg::SLEEPY_SPLIT)) ?
                        mlpg_pkg::SLEEPY_HIGH : mlpg_pkg::SLEEPY_LOW;
         end
         mlpg_pkg::MODE_TRIPLE: begin
            step_next = {2'd0, wrap8_s};
            led_mask  = rot_dbl[15:8];
         end
         mlpg_pkg::MODE_TALKING: begin
            step_next = {2'd0, talk_s};
            led_mask  = (8'd1 << talk_s) | (8'd1 << (3'd7 - talk_s));
         end
         mlpg_pkg::MODE_SAD: begin
            led_mask = mlpg_pkg::SAD_MASK;
         end
         mlpg_pkg::MODE_SWEEP: begin
            step_next = {2'd0, wrap8_s};
            led_mask  = (8'd1 << wrap8_s) | (8'd1 << (3'd7 - wrap8_s));
         end
         mlpg_pkg::MODE_CUSTOM: begin
            led_mask = stored_mask;
         end
         default: begin
            led_mask  = '0;
            step_next = step;
         end
      endcase
   end

endmodule

FILE: rtl/mlpg_state.sv
// mood state, prescaler and talking timer, updated once per processed item
module mlpg_state #(
   parameter int unsigned MAX_TEXT_LENGTH = mlpg_pkg::MAX_TEXT_LENGTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  mlpg_pkg::item_type   item,
   input  mlpg_pkg::cfg_type    cfg,
   output mlpg_pkg::result_type result
);

   logic [7:0]  prescale_ff, prescale_in;
   logic [7:0]  mode_ff, mode_in;
   logic [7:0]  smask_ff, smask_in;
   logic [4:0]  step_ff, step_in;
   logic [15:0] timer_ff, timer_in;

   logic [7:0]  mode_tick;
   logic [4:0]  step_tick;
   logic [7:0]  divider;
   logic [7:0]  prescale_inc;
   logic [7:0]  len_clamped;
   logic [15:0] talk_ticks;
   logic [7:0]  pat_mask;
   logic [4:0]  pat_step;

   // talking mode falls back to idle when the timer runs out on a tick
   always_comb begin
      mode_tick = mode_ff;
      step_tick = step_ff;
      if (timer_ff == 16'd1 && mode_ff == mlpg_pkg::MODE_TALKING) begin
         mode_tick = mlpg_pkg::MODE_IDLE;
         step_tick = '0;
      end
   end

   mlpg_pattern u_pattern (
      .mode        (mode_tick),
      .step        (step_tick),
      .stored_mask (smask_ff),
      .led_mask    (pat_mask),
      .step_next   (pat_step)
   );

   // prescaler and talking duration
   always_comb begin
      divider      = (cfg.refresh_divider == '0) ? 8'd1 : cfg.refresh_divider;
      prescale_inc = prescale_ff + 8'd1;
      len_clamped  = (item.text_length > 8'(MAX_TEXT_LENGTH)) ?
                     8'(MAX_TEXT_LENGTH) : item.text_length;
      // at most 255 * 255 + 255, so sixteen bits never overflow
      talk_ticks   = 16'(cfg.talk_base_ticks) + 16'(len_clamped) * 16'(cfg.talk_ticks_per_byte);
   end

   // next state per item kind
   always_comb begin
      prescale_in     = prescale_ff;
      mode_in         = mode_ff;
      smask_in        = smask_ff;
      step_in         = step_ff;
      timer_in        = timer_ff;
      result.emit     = 1'b0;
      result.led_mask = pat_mask;
      if (fire) begin
         case (item.kind)
            mlpg_pkg::KIND_TICK: begin
               if (timer_ff != '0) begin
                  timer_in = timer_ff - 16'd1;
               end
               mode_in = mode_tick;
               if (prescale_inc >= divider) begin
                  prescale_in = '0;
                  step_in     = pat_step;
                  result.emit = 1'b1;
               end else begin
                  prescale_in = prescale_inc;
                  step_in     = step_tick;
               end
            end
            mlpg_pkg::KIND_SET_MODE: begin
               mode_in  = item.mode_code;
               smask_in = item.mask_value;
               step_in  = '0;
            end
            mlpg_pkg::KIND_TALK_START: begin
               if (item.text_length != '0) begin
                  mode_in  = mlpg_pkg::MODE_TALKING;
                  step_in  = '0;
                  timer_in = talk_ticks;
               end
            end
            default: begin
               prescale_in = prescale_ff;
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff <= '0;
         mode_ff     <= mlpg_pkg::MODE_IDLE;
         smask_ff    <= '0;
         step_ff     <= '0;
         timer_ff    <= '0;
      end else begin
         prescale_ff <= prescale_in;
         mode_ff     <= mode_in;
         smask_ff    <= smask_in;
         step_ff     <= step_in;
         timer_ff    <= timer_in;
      end
   end

endmodule

FILE: rtl/led_mood_pattern_generator.sv
// top level of the led mood pattern generator: channels, registers and output stage
//
//   channel | direction | handshake             | payload
//   req     | in        | req_tvalid/req_tready | tuser kind, tdata mode/mask/length
//   rsp     | out       | rsp_tvalid/rsp_tready | tdata led_mask
//   csr     | in        | csr_valid/csr_ready   | csr_index, csr_data
//
// one transaction per cycle sustained while rsp_tready stays high; a tick that refreshes
// passes the input register at the accepting edge and then the result register before
// its mask shows on rsp_tdata
// reset is synchronous: mood idle, counters and timer zero, registers at defaults
// a stalled result holds the output register; an empty input register still takes one
// more transaction, after that req_tready drops until the result is taken
module led_mood_pattern_generator #(
   parameter int unsigned MAX_TEXT_LENGTH = mlpg_pkg::MAX_TEXT_LENGTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [mlpg_pkg::REQ_DATA_W-1:0]   req_tdata,   // mode_code, mask_value, text_length
   input  logic [1:0]                        req_tuser,   // kind
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [7:0]                        rsp_tdata,   // led_mask
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [1:0]                        csr_index,
   input  logic [7:0]                        csr_data
);

   logic                 in_valid_ff, in_valid_in;
   mlpg_pkg::item_type   in_item_ff, in_item_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_data_ff, rsp_data_in;
   mlpg_pkg::cfg_type    cfg_ff, cfg_in;
   mlpg_pkg::result_type result;
   logic                 fire;
   logic                 req_take;

   // handshake control
   always_comb begin
      fire       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
      req_tready = !in_valid_ff || fire;
      req_take   = req_tvalid && req_tready;
      csr_ready  = 1'b1;
   end

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_take) begin
         in_valid_in            = 1'b1;
         in_item_in.kind        = mlpg_pkg::kind_type'(req_tuser);
         in_item_in.mode_code   = req_tdata[7:0];
         in_item_in.mask_value  = req_tdata[15:8];
         in_item_in.text_length = req_tdata[23:16];
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   // configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (mlpg_pkg::csr_index_type'(csr_index))
            mlpg_pkg::CSR_REFRESH_DIVIDER:     cfg_in.refresh_divider     = csr_data;
            mlpg_pkg::CSR_TALK_BASE_TICKS:     cfg_in.talk_base_ticks     = csr_data;
            mlpg_pkg::CSR_TALK_TICKS_PER_BYTE: cfg_in.talk_ticks_per_byte = csr_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   mlpg_state #(
      .MAX_TEXT_LENGTH (MAX_TEXT_LENGTH)
   ) u_state (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_item_ff),
      .cfg    (cfg_ff),
      .result (result)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (fire) begin
         rsp_valid_in = result.emit;
         if (result.emit) begin
            rsp_data_in = result.led_mask;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff                <= 1'b0;
         rsp_valid_ff               <= 1'b0;
         cfg_ff.refresh_divider     <= mlpg_pkg::REFRESH_DIVIDER_RST;
         cfg_ff.talk_base_ticks     <= mlpg_pkg::TALK_BASE_TICKS_RST;
         cfg_ff.talk_ticks_per_byte <= mlpg_pkg::TALK_TICKS_PER_BYTE_RST;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // both stages full and output stalled: no room for another transaction
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("input taken while both stages are full");

   // only a tick can produce a result
   a_non_tick_silent: assert property (@(posedge clock) disable iff (reset)
      (fire && in_item_ff.kind != mlpg_pkg::KIND_TICK) |=> !rsp_tvalid)
      else $error("result produced by a non-tick item");

   // after reset both stages are empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("stages not empty after reset");

endmodule
